FILE: rtl/core/dq_pkg.sv
// Shared types and constants of the double-ended queue.
package dq_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned OCC_W  = 8;

  // Word returned by a pop from an empty queue (all ones, that is -1).
  localparam logic [WORD_W-1:0] UNDERFLOW_WORD = '1;

  typedef enum logic [1:0] {
    FUNC_PUSH_FRONT = 2'd0,
    FUNC_PUSH_REAR  = 2'd1,
    FUNC_POP_FRONT  = 2'd2,
    FUNC_POP_REAR   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    func_e                     func;
    logic signed [WORD_W-1:0]  push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0]  pop_value;
    status_e                   status;
    logic        [OCC_W-1:0]   occupancy;
  } out_item_t;

  // Operation broadcast to every cell; at most one bit is set per cycle.
  typedef struct packed {
    logic add_front;
    logic add_rear;
    logic take_front;
    logic take_rear;
  } cell_cmd_t;

endpackage

FILE: rtl/core/dq_cell.sv
// One storage cell of the queue chain: a word and its occupied flag.
module dq_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dq_pkg::cell_cmd_t          cmd_i,
  input  logic [dq_pkg::WORD_W-1:0]  push_value_i,
  input  logic                       left_valid_i,
  input  logic [dq_pkg::WORD_W-1:0]  left_data_i,
  input  logic                       right_valid_i,
  input  logic [dq_pkg::WORD_W-1:0]  right_data_i,
  output logic                       valid_o,
  output logic [dq_pkg::WORD_W-1:0]  data_o,
  output logic                       last_o
);

  logic                      valid_q, valid_d;
  logic [dq_pkg::WORD_W-1:0] data_q, data_d;

  // Words sit packed from the front cell; front operations shift the whole
  // row by one, rear operations touch only the boundary cell.
  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (cmd_i.add_front) begin
      valid_d = left_valid_i;
      data_d  = left_data_i;
    end else if (cmd_i.take_front) begin
      valid_d = right_valid_i;
      data_d  = right_data_i;
    end else if (cmd_i.add_rear && !valid_q && left_valid_i) begin
      valid_d = 1'b1;
      data_d  = push_value_i;
    end else if (cmd_i.take_rear && valid_q && !right_valid_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign last_o  = valid_q & ~right_valid_i;

endmodule

FILE: rtl/core/dq_gather.sv
// Two-level registered gather of the rear word from the cell row.
module dq_gather #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic                                     clk_i,
  input  logic [CAPACITY-1:0]                      last_i,
  input  logic [CAPACITY-1:0][dq_pkg::WORD_W-1:0]  data_i,
  output logic [dq_pkg::WORD_W-1:0]                word_o
);

  localparam int unsigned GROUP = 16;
  localparam int unsigned NGRP  = (CAPACITY + GROUP - 1) / GROUP;
  localparam int unsigned PAD   = NGRP * GROUP;

  logic [PAD-1:0]                      last_pad;
  logic [PAD-1:0][dq_pkg::WORD_W-1:0]  data_pad;
  logic [NGRP-1:0][dq_pkg::WORD_W-1:0] group_q, group_d;

  always_comb begin
    last_pad = '0;
    data_pad = '0;
    last_pad[CAPACITY-1:0] = last_i;
    data_pad[CAPACITY-1:0] = data_i;
  end

  // At most one cell is flagged as last, so an AND-OR picks its word.
  always_comb begin
    group_d = '0;
    for (int g = 0; g < NGRP; g++) begin
      for (int k = 0; k < GROUP; k++) begin
        group_d[g] = group_d[g]
                   | (data_pad[g*GROUP+k] & {dq_pkg::WORD_W{last_pad[g*GROUP+k]}});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    group_q <= group_d;
  end

  always_comb begin
    word_o = '0;
    for (int g = 0; g < NGRP; g++) begin
      word_o = word_o | group_q[g];
    end
  end

endmodule

FILE: rtl/core/double_ended_queue.sv
// Top level of the double-ended queue built as a row of shifting cells.
//
// Usage: one input channel (in_valid_i / in_ready_o / in_item_i) carries an
// operation and a push word; one output channel (out_valid_o / out_ready_i /
// out_item_o) returns exactly one result per operation, in order.
// Words are held in a row of CAPACITY cells packed from the front cell. A
// front push or pop shifts every cell by one place in the same cycle; a rear
// push or pop touches only the cell at the boundary of the occupied run.
// A result is registered into the output buffer when its transfer is accepted,
// except a successful rear pop, whose word is collected through a two-level
// registered gather over the cells before its result is written.
// One operation per cycle is taken while in_ready_o is high; a successful
// rear pop holds the input low while the gather stage drains.
// Results go into a two-entry output buffer, so a stalled receiver does not
// stop the queue until both entries are full; then in_ready_o drops.
// Reset clears every occupied flag, the word count and the output buffer;
// the cell words themselves are not reset.
module double_ended_queue #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dq_pkg::in_item_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dq_pkg::out_item_t out_item_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  // Handshake and queue status.
  logic             in_xfer;
  logic             out_xfer;
  logic [CNT_W-1:0] count_q, count_d;
  logic             full;
  logic             empty;
  dq_pkg::cell_cmd_t cmd;

  // Cell row: the left neighbor of the front cell is the push word, and the
  // right neighbor of the rear cell is tied to an always-empty cell.
  logic [CAPACITY-1:0]                   chain_valid;
  logic [CAPACITY-1:0][dq_pkg::WORD_W-1:0] chain_data;
  logic [CAPACITY-1:0]                   cell_valid;
  logic [CAPACITY-1:0][dq_pkg::WORD_W-1:0] cell_data;
  logic [CAPACITY-1:0]                   cell_last;
  logic [dq_pkg::WORD_W-1:0]             rear_word;

  // Result assembly.
  dq_pkg::out_item_t res;
  dq_pkg::out_item_t pend_q;
  logic              gather_q;
  logic [CNT_W+dq_pkg::OCC_W-1:0] occ_ext;

  // Output buffer.
  dq_pkg::out_item_t buf_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        ob_cnt_q;
  logic              ob_wr;
  dq_pkg::out_item_t ob_wr_item;

  assign in_ready_o = !gather_q && (ob_cnt_q != 2'd2);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign full       = (count_q == CNT_W'(CAPACITY));
  assign empty      = (count_q == '0);

  always_comb begin
    cmd = '0;
    if (in_xfer) begin
      unique case (in_item_i.func)
        dq_pkg::FUNC_PUSH_FRONT: cmd.add_front  = !full;
        dq_pkg::FUNC_PUSH_REAR:  cmd.add_rear   = !full;
        dq_pkg::FUNC_POP_FRONT:  cmd.take_front = !empty;
        dq_pkg::FUNC_POP_REAR:   cmd.take_rear  = !empty;
        default:                 cmd = '0;
      endcase
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd.add_front || cmd.add_rear) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd.take_front || cmd.take_rear) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // The left neighbor of the front cell is the incoming word, so a front
  // push is just a shift of the whole row toward the rear.
  assign chain_valid[0] = 1'b1;
  assign chain_data[0]  = in_item_i.push_value;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    dq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .push_value_i  (in_item_i.push_value),
      .left_valid_i  (chain_valid[i]),
      .left_data_i   (chain_data[i]),
      .right_valid_i ((i + 1 < CAPACITY) ? cell_valid[(i+1) % CAPACITY] : 1'b0),
      .right_data_i  ((i + 1 < CAPACITY) ? cell_data[(i+1) % CAPACITY] : '0),
      .valid_o       (cell_valid[i]),
      .data_o        (cell_data[i]),
      .last_o        (cell_last[i])
    );
    if (i + 1 < CAPACITY) begin : g_link
      assign chain_valid[i+1] = cell_valid[i];
      assign chain_data[i+1]  = cell_data[i];
    end
  end

  dq_gather #(
    .CAPACITY (CAPACITY)
  ) u_gather (
    .clk_i  (clk_i),
    .last_i (cell_last),
    .data_i (cell_data),
    .word_o (rear_word)
  );

  // Occupancy is reported modulo 256.
  assign occ_ext = {{dq_pkg::OCC_W{1'b0}}, count_d};

  always_comb begin
    res.occupancy = occ_ext[dq_pkg::OCC_W-1:0];
    res.status    = dq_pkg::STATUS_OK;
    res.pop_value = '0;
    unique case (in_item_i.func) inside
      dq_pkg::FUNC_PUSH_FRONT,
      dq_pkg::FUNC_PUSH_REAR: begin
        if (full) begin
          res.status = dq_pkg::STATUS_OVERFLOW;
        end
      end
      dq_pkg::FUNC_POP_FRONT,
      dq_pkg::FUNC_POP_REAR: begin
        if (empty) begin
          res.status    = dq_pkg::STATUS_UNDERFLOW;
          res.pop_value = dq_pkg::UNDERFLOW_WORD;
        end else if (in_item_i.func == dq_pkg::FUNC_POP_FRONT) begin
          res.pop_value = cell_data[0];
        end
      end
      default: res.pop_value = '0;
    endcase
  end

  // A rear pop parks its status and occupancy until the gather finishes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gather_q <= 1'b0;
    end else begin
      gather_q <= cmd.take_rear;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.take_rear) begin
      pend_q <= res;
    end
  end

  always_comb begin
    ob_wr      = (in_xfer && !cmd.take_rear) || gather_q;
    ob_wr_item = res;
    if (gather_q) begin
      ob_wr_item           = pend_q;
      ob_wr_item.pop_value = rear_word;
    end
  end

  assign out_valid_o = (ob_cnt_q != 2'd0);
  assign out_xfer    = out_valid_o && out_ready_i;
  assign out_item_o  = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      ob_cnt_q <= 2'd0;
    end else begin
      if (ob_wr) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (out_xfer) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (ob_wr && !out_xfer) begin
        ob_cnt_q <= ob_cnt_q + 2'd1;
      end else if (!ob_wr && out_xfer) begin
        ob_cnt_q <= ob_cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ob_wr) begin
      buf_q[wr_ptr_q] <= ob_wr_item;
    end
  end

endmodule

FILE: rtl/core/dq_checker.sv
// Port-level checks of the double-ended queue and their binding.
module dq_checker #(
  parameter int unsigned CAPACITY = 128
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input dq_pkg::in_item_t  in_item_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input dq_pkg::out_item_t out_item_o
);

  localparam logic [dq_pkg::OCC_W-1:0] CAP_OCC = dq_pkg::OCC_W'(CAPACITY);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn before transfer");

  // An underflow always leaves the queue empty and returns all ones.
  a_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == dq_pkg::STATUS_UNDERFLOW |->
      out_item_o.occupancy == '0 && out_item_o.pop_value == -32'sd1)
    else $error("underflow result inconsistent");

  // An overflow is only reported on a full queue and carries a zero word.
  a_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == dq_pkg::STATUS_OVERFLOW |->
      out_item_o.occupancy == CAP_OCC && out_item_o.pop_value == '0)
    else $error("overflow result inconsistent");

  // Right after reset no result is pending and the input is open.
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o && (in_ready_o || !rst_ni) && !(in_valid_i && !in_ready_o
      && !rst_ni && in_item_i.func == dq_pkg::FUNC_POP_REAR))
    else $error("block not idle after reset");

endmodule

bind double_ended_queue dq_checker #(.CAPACITY(CAPACITY)) u_dq_checker (.*);
